/* hw/rtl/tdms_pkg.sv */
// Shared types, constants and helper functions for the decimal minimum scanner.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package tdms_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned FracDigitsDefault = 5;
  localparam int unsigned ValueWidthDefault = 48;

  // Width of the min_value field on the result channel
  localparam int unsigned OutWidth = 48;

  // Entries in the queue between classifier and scanner
  localparam int unsigned QueueDepth = 2;

  // Width that holds a digit times the largest power of ten that is used (9 * 10^7)
  localparam int unsigned ProdWidth = 31;

  localparam logic [7:0] CharDot  = 8'h2E;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  // One character after classification
  typedef struct packed {
    logic       is_digit;
    logic       is_dot;
    logic       last;
    logic [3:0] digit_val;
  } char_class_t;

  function automatic logic [26:0] pow10(input logic [2:0] exp_i);
    logic [26:0] r;
    unique case (exp_i)
      3'd0: r = 27'd1;
      3'd1: r = 27'd10;
      3'd2: r = 27'd100;
      3'd3: r = 27'd1000;
      3'd4: r = 27'd10000;
      3'd5: r = 27'd100000;
      3'd6: r = 27'd1000000;
      3'd7: r = 27'd10000000;
      default: r = 27'd1;
    endcase
    return r;
  endfunction

  // Digit scaled by a power of ten, not yet saturated
  function automatic logic [ProdWidth-1:0] scaled_digit(input logic [3:0] d_i,
                                                        input logic [2:0] exp_i);
    logic [ProdWidth-1:0] r;
    r = ProdWidth'(d_i) * ProdWidth'(pow10(exp_i));
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tdms_if.sv */
// Valid/ready channel interfaces for the scanner: character requests in, results out.
// Depends on tdms_pkg for the result field width.
`default_nettype none

interface tdms_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface tdms_result_if;
  logic                           valid;
  logic                           ready;
  logic [tdms_pkg::OutWidth-1:0]  min_value;
  logic                           found;
  logic                           malformed;

  modport source (output valid, output min_value, output found, output malformed,
                  input ready);
  modport sink   (input valid, input min_value, input found, input malformed,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/tdms_front.sv */
// Front end: takes character requests, classifies them and pre-scales an integer digit.
// Depends on tdms_pkg and tdms_char_if.
`default_nettype none

module tdms_front #(
  parameter int unsigned FRAC_DIGITS = tdms_pkg::FracDigitsDefault,
  parameter int unsigned VALUE_WIDTH = tdms_pkg::ValueWidthDefault
) (
  tdms_char_if.sink                 char_i,
  input  logic                      full_i,
  output logic                      push_o,
  output tdms_pkg::char_class_t     cls_o,
  output logic [VALUE_WIDTH-1:0]    int_add_o
);

  localparam int unsigned CmpW = (VALUE_WIDTH > tdms_pkg::ProdWidth) ?
                                 VALUE_WIDTH : tdms_pkg::ProdWidth;
  localparam logic [VALUE_WIDTH-1:0] VMax = '1;

  logic                           is_digit;
  logic [3:0]                     dval;
  logic [tdms_pkg::ProdWidth-1:0] prod;

  assign char_i.ready = !full_i;
  assign push_o       = char_i.valid && !full_i;

  assign is_digit = (char_i.char_code >= tdms_pkg::CharZero) &&
                    (char_i.char_code <= tdms_pkg::CharNine);
  assign dval     = is_digit ? 4'(char_i.char_code - tdms_pkg::CharZero) : 4'd0;

  assign cls_o.is_digit  = is_digit;
  assign cls_o.is_dot    = (char_i.char_code == tdms_pkg::CharDot);
  assign cls_o.last      = char_i.last_char;
  assign cls_o.digit_val = dval;

  // Integer digit weight: d * 10^FRAC_DIGITS, clipped to the value range
  assign prod      = tdms_pkg::scaled_digit(dval, 3'(FRAC_DIGITS));
  assign int_add_o = (CmpW'(prod) > CmpW'(VMax)) ? VMax : VALUE_WIDTH'(prod);

endmodule

`default_nettype wire

/* hw/rtl/tdms_queue.sv */
// Small register queue between the classifier and the scanner.
// Depends on tdms_pkg for the default depth.
`default_nettype none

module tdms_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = tdms_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tdms_back.sv */
// Back end: number scanner state, running minimum and the result register.
// Depends on tdms_pkg and tdms_result_if.
`default_nettype none

module tdms_back #(
  parameter int unsigned FRAC_DIGITS = tdms_pkg::FracDigitsDefault,
  parameter int unsigned VALUE_WIDTH = tdms_pkg::ValueWidthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  tdms_pkg::char_class_t     cls_i,
  input  logic [VALUE_WIDTH-1:0]    int_add_i,
  output logic                      pop_o,
  tdms_result_if.source             res_o
);

  localparam int unsigned VW   = VALUE_WIDTH;
  localparam int unsigned CmpW = (VW > tdms_pkg::ProdWidth) ? VW : tdms_pkg::ProdWidth;
  localparam int unsigned OutExtW = (VW > tdms_pkg::OutWidth) ? VW : tdms_pkg::OutWidth;
  localparam logic [VW-1:0] VMax = '1;

  // Scanner state
  logic [VW-1:0] accum_q, accum_d;
  logic [2:0]    frac_cnt_q, frac_cnt_d;
  logic          in_num_q, in_num_d;
  logic          dot_seen_q, dot_seen_d;
  logic          dot_pend_q, dot_pend_d;
  logic          dot2_pend_q, dot2_pend_d;
  logic [VW-1:0] best_q, best_d;
  logic          found_q, found_d;
  logic          bad_q, bad_d;

  // Result register; the close of a still-open number happens on the way out
  logic          out_valid_q;
  logic [VW-1:0] out_best_q, out_accum_q;
  logic          out_open_q, out_found_q, out_bad_q;

  logic                           take;
  logic                           d_is;
  logic [tdms_pkg::ProdWidth-1:0] frac_prod;
  logic [VW-1:0]                  frac_add;
  logic [VW+4:0]                  int_sum;
  logic [VW:0]                    frac_sum;
  logic [VW-1:0]                  int_res, frac_res;
  logic                           frac_room;
  logic [VW-1:0]                  closed_best;

  logic          sel_open;
  logic [VW-1:0] sel_min;
  logic [OutExtW-1:0] out_ext;

  assign pop_o = valid_i && (!cls_i.last || !out_valid_q || res_o.ready);
  assign take  = pop_o;
  assign d_is  = cls_i.is_digit;

  // accum * 10 + integer weight; overflow past the range saturates
  assign int_sum = ((VW+5)'(accum_q) << 3) + ((VW+5)'(accum_q) << 1) + (VW+5)'(int_add_i);
  assign int_res = (int_sum > (VW+5)'(VMax)) ? VMax : int_sum[VW-1:0];

  assign frac_prod = tdms_pkg::scaled_digit(cls_i.digit_val,
                                            3'(FRAC_DIGITS) - 3'd1 - frac_cnt_q);
  assign frac_add  = (CmpW'(frac_prod) > CmpW'(VMax)) ? VMax : VW'(frac_prod);
  assign frac_sum  = {1'b0, accum_q} + {1'b0, frac_add};
  assign frac_res  = frac_sum[VW] ? VMax : frac_sum[VW-1:0];
  assign frac_room = (frac_cnt_q < 3'(FRAC_DIGITS));

  assign closed_best = (accum_q < best_q) ? accum_q : best_q;

  always_comb begin
    accum_d     = accum_q;
    frac_cnt_d  = frac_cnt_q;
    in_num_d    = in_num_q;
    dot_seen_d  = dot_seen_q;
    dot_pend_d  = dot_pend_q;
    dot2_pend_d = 1'b0;
    best_d      = best_q;
    found_d     = found_q;
    bad_d       = bad_q || (dot2_pend_q && d_is);

    priority if (dot_pend_q) begin
      dot_pend_d = 1'b0;
      if (d_is) begin
        dot_seen_d = 1'b1;
        if (frac_room) begin
          accum_d    = frac_res;
          frac_cnt_d = frac_cnt_q + 3'd1;
        end
      end else begin
        best_d     = closed_best;
        found_d    = 1'b1;
        accum_d    = '0;
        frac_cnt_d = '0;
        in_num_d   = 1'b0;
        dot_seen_d = 1'b0;
      end
    end else if (in_num_q) begin
      if (d_is) begin
        if (!dot_seen_q) begin
          accum_d = int_res;
        end else if (frac_room) begin
          accum_d    = frac_res;
          frac_cnt_d = frac_cnt_q + 3'd1;
        end
      end else if (cls_i.is_dot && !dot_seen_q) begin
        dot_pend_d = 1'b1;
      end else begin
        // any other character, or a second dot, ends the number
        best_d      = closed_best;
        found_d     = 1'b1;
        accum_d     = '0;
        frac_cnt_d  = '0;
        in_num_d    = 1'b0;
        dot_seen_d  = 1'b0;
        dot2_pend_d = cls_i.is_dot;
      end
    end else if (d_is) begin
      accum_d    = int_add_i;
      frac_cnt_d = '0;
      dot_seen_d = 1'b0;
      in_num_d   = 1'b1;
    end else begin
      accum_d = accum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q     <= '0;
      frac_cnt_q  <= '0;
      in_num_q    <= 1'b0;
      dot_seen_q  <= 1'b0;
      dot_pend_q  <= 1'b0;
      dot2_pend_q <= 1'b0;
      best_q      <= '1;
      found_q     <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take && cls_i.last) begin
        // text done: start over for the next one
        accum_q     <= '0;
        frac_cnt_q  <= '0;
        in_num_q    <= 1'b0;
        dot_seen_q  <= 1'b0;
        dot_pend_q  <= 1'b0;
        dot2_pend_q <= 1'b0;
        best_q      <= '1;
        found_q     <= 1'b0;
        bad_q       <= 1'b0;
      end else if (take) begin
        accum_q     <= accum_d;
        frac_cnt_q  <= frac_cnt_d;
        in_num_q    <= in_num_d;
        dot_seen_q  <= dot_seen_d;
        dot_pend_q  <= dot_pend_d;
        dot2_pend_q <= dot2_pend_d;
        best_q      <= best_d;
        found_q     <= found_d;
        bad_q       <= bad_d;
      end
      if (take && cls_i.last) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cls_i.last) begin
      out_best_q  <= best_d;
      out_accum_q <= accum_d;
      out_open_q  <= in_num_d;
      out_found_q <= found_d;
      out_bad_q   <= bad_d;
    end
  end

  assign sel_open = out_open_q && (out_accum_q < out_best_q);
  assign sel_min  = sel_open ? out_accum_q : out_best_q;
  assign out_ext  = (out_found_q || out_open_q) ? OutExtW'(sel_min) : '0;

  assign res_o.valid     = out_valid_q;
  assign res_o.min_value = out_ext[tdms_pkg::OutWidth-1:0];
  assign res_o.found     = out_found_q || out_open_q;
  assign res_o.malformed = out_bad_q;

endmodule

`default_nettype wire

/* hw/rtl/text_decimal_minimum_scanner.sv */
// Top level of the decimal minimum scanner: classifier, queue and scanner.
// Depends on tdms_pkg, tdms_if, tdms_front, tdms_queue and tdms_back.
//
//   channel   dir  handshake        payload
//   char_i    in   valid / ready    char_code[7:0], last_char
//   result_o  out  valid / ready    min_value[47:0], found, malformed
//
// One character a cycle, sustained, unless a character marked last waits on a
// full result register. A result is registered as its last char is taken.
// The scanner's multiply-by-ten add and saturation sets the cycle time.
// A two-entry queue parts classifier and scanner; only a character marked
// last waits on a full result register, others flow on while a result stalls.
// Reset clears all scan state; no clearing pass is needed.
`default_nettype none

module text_decimal_minimum_scanner #(
  parameter int unsigned FRAC_DIGITS = tdms_pkg::FracDigitsDefault,
  parameter int unsigned VALUE_WIDTH = tdms_pkg::ValueWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tdms_char_if.sink     char_i,
  tdms_result_if.source result_o
);

  localparam int unsigned ClsW   = $bits(tdms_pkg::char_class_t);
  localparam int unsigned EntryW = VALUE_WIDTH + ClsW;

  logic                   push, full, pop, q_valid;
  tdms_pkg::char_class_t  f_cls, b_cls;
  logic [VALUE_WIDTH-1:0] f_add, b_add;
  logic [EntryW-1:0]      q_out;

  tdms_front #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .char_i    (char_i),
    .full_i    (full),
    .push_o    (push),
    .cls_o     (f_cls),
    .int_add_o (f_add)
  );

  tdms_queue #(
    .DATA_W (EntryW),
    .DEPTH  (tdms_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_add, f_cls}),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign b_cls = q_out[ClsW-1:0];
  assign b_add = q_out[EntryW-1:ClsW];

  tdms_back #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .cls_i     (b_cls),
    .int_add_i (b_add),
    .pop_o     (pop),
    .res_o     (result_o)
  );

endmodule

`default_nettype wire

/* dv/tdms_min_checker.sv */
// Passive checker for the decimal minimum scanner: follows both channels, predicts each result.
// Depends on tdms_pkg for character codes and widths, and on tdms_if for the channel interfaces.
`default_nettype none

module tdms_min_checker #(
  parameter int unsigned FRAC_DIGITS = tdms_pkg::FracDigitsDefault,
  parameter int unsigned VALUE_WIDTH = tdms_pkg::ValueWidthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tdms_char_if   char_mon,
  tdms_result_if result_mon,
  output int     fail_count_o,
  output int     pending_o
);

  localparam logic [63:0] ValueMax = {64{1'b1}} >> (64 - VALUE_WIDTH);

  typedef struct packed {
    logic [tdms_pkg::OutWidth-1:0] min_value;
    logic                          found;
    logic                          malformed;
  } scan_result_t;

  scan_result_t expected_minima[$];
  int           mismatches = 0;

  logic [63:0] number_acc;
  logic [63:0] lowest;
  int unsigned frac_taken;
  logic        in_number;
  logic        dot_taken;
  logic        dot_waiting;
  logic        second_dot_waiting;
  logic        any_number;
  logic        second_dot_bad;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [63:0] digit_weight(input logic [3:0] d, input int unsigned e);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < int'(e & 7); i++) p = p * 10;
    p = p * d;
    return (p > ValueMax) ? ValueMax : p;
  endfunction

  task automatic add_integer_digit(input logic [3:0] d);
    logic [63:0] w;
    w = digit_weight(d, FRAC_DIGITS);
    if (number_acc > (ValueMax - w) / 10) number_acc = ValueMax;
    else number_acc = number_acc * 10 + w;
  endtask

  // digits past the kept precision are dropped
  task automatic add_fraction_digit(input logic [3:0] d);
    logic [63:0] w;
    if (frac_taken < FRAC_DIGITS) begin
      w = digit_weight(d, FRAC_DIGITS - 1 - frac_taken);
      if (number_acc > ValueMax || w > ValueMax - number_acc) number_acc = ValueMax;
      else number_acc = number_acc + w;
      frac_taken++;
    end
  endtask

  task automatic close_number();
    if (number_acc < lowest) lowest = number_acc;
    any_number  = 1'b1;
    number_acc  = '0;
    frac_taken  = 0;
    in_number   = 1'b0;
    dot_taken   = 1'b0;
    dot_waiting = 1'b0;
  endtask

  task automatic clear_scan();
    number_acc         = '0;
    frac_taken         = 0;
    in_number          = 1'b0;
    dot_taken          = 1'b0;
    dot_waiting        = 1'b0;
    second_dot_waiting = 1'b0;
    lowest             = ValueMax;
    any_number         = 1'b0;
    second_dot_bad     = 1'b0;
  endtask

  task automatic take_char(input logic [7:0] c, input logic last);
    logic         is_digit;
    logic [3:0]   d;
    scan_result_t res;
    is_digit = (c >= tdms_pkg::CharZero) && (c <= tdms_pkg::CharNine);
    d        = is_digit ? 4'(c - tdms_pkg::CharZero) : 4'd0;

    // a digit right after a closing second dot marks the text malformed
    if (second_dot_waiting) begin
      second_dot_waiting = 1'b0;
      if (is_digit) second_dot_bad = 1'b1;
    end

    if (dot_waiting) begin
      dot_waiting = 1'b0;
      if (is_digit) begin
        dot_taken = 1'b1;
        add_fraction_digit(d);
      end else begin
        close_number();
      end
    end else if (in_number) begin
      if (is_digit) begin
        if (dot_taken) add_fraction_digit(d);
        else add_integer_digit(d);
      end else if (c == tdms_pkg::CharDot) begin
        if (!dot_taken) begin
          dot_waiting = 1'b1;
        end else begin
          close_number();
          second_dot_waiting = 1'b1;
        end
      end else begin
        close_number();
      end
    end else if (is_digit) begin
      number_acc = digit_weight(d, FRAC_DIGITS);
      frac_taken = 0;
      dot_taken  = 1'b0;
      in_number  = 1'b1;
    end

    if (last) begin
      if (in_number) close_number();
      res.min_value = any_number ? lowest[tdms_pkg::OutWidth-1:0] : '0;
      res.found     = any_number;
      res.malformed = second_dot_bad;
      expected_minima.push_back(res);
      clear_scan();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t want;
    if (!rst_ni) begin
      clear_scan();
      expected_minima.delete();
      pending_o <= 0;
    end else begin
      // results go first: a request taken at this edge cannot be answered at it
      if (result_mon.valid && result_mon.ready) begin
        if (expected_minima.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending (min_value %0d)",
                                    result_mon.min_value));
        end else begin
          want = expected_minima.pop_front();
          if (result_mon.min_value !== want.min_value)
            report_mismatch($sformatf("min_value %0d, expected %0d",
                                      result_mon.min_value, want.min_value));
          if (result_mon.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b",
                                      result_mon.found, want.found));
          if (result_mon.malformed !== want.malformed)
            report_mismatch($sformatf("malformed %0b, expected %0b",
                                      result_mon.malformed, want.malformed));
        end
      end
      if (char_mon.valid && char_mon.ready) take_char(char_mon.char_code, char_mon.last_char);
      pending_o <= expected_minima.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

`default_nettype wire

/* dv/text_decimal_minimum_scanner_test.sv */
// Top of the scanner testbench: clock, reset, character requests and result stalls, verdict.
// Depends on tdms_pkg, tdms_if, the scanner RTL and tdms_min_checker.
`default_nettype none

module text_decimal_minimum_scanner_test;

  logic clk_i;
  logic rst_ni;

  tdms_char_if   char_bus ();
  tdms_result_if result_bus ();

  int   checker_fails;
  int   checker_pending;
  logic sender_no_gaps = 1'b0;
  logic taker_no_stalls = 1'b0;

  logic [7:0] text_buf[$];

  text_decimal_minimum_scanner u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_bus),
    .result_o (result_bus)
  );

  tdms_min_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_mon     (char_bus),
    .result_mon   (result_bus),
    .fail_count_o (checker_fails),
    .pending_o    (checker_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // valid stays high between back-to-back requests
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    char_bus.last_char <= last;
    do @(posedge clk_i); while (!char_bus.ready);
  endtask

  task automatic send_text();
    sender_no_gaps = ($urandom_range(0, 3) == 0);
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic load_string(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic append_digits(input int n);
    for (int i = 0; i < n; i++) text_buf.push_back(8'(tdms_pkg::CharZero + $urandom_range(0, 9)));
  endtask

  task automatic append_separator();
    case ($urandom_range(0, 3))
      0:       text_buf.push_back(" ");
      1:       text_buf.push_back(",");
      2:       text_buf.push_back(8'("a" + $urandom_range(0, 25)));
      default: text_buf.push_back(8'("A" + $urandom_range(0, 25)));
    endcase
  endtask

  task automatic append_token();
    int kind;
    int r;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      r = $urandom_range(0, 19);
      if (r < 14)      append_digits($urandom_range(1, 4));
      else if (r < 19) append_digits($urandom_range(5, 9));
      else             append_digits($urandom_range(10, 14));   // may saturate
      if ($urandom_range(0, 1)) begin
        text_buf.push_back(tdms_pkg::CharDot);
        append_digits($urandom_range(1, 8));
      end
    end else if (kind < 70) begin
      append_separator();
    end else if (kind < 80) begin
      text_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      // dot with no digit after it
      append_digits($urandom_range(1, 3));
      text_buf.push_back(tdms_pkg::CharDot);
      if ($urandom_range(0, 1)) text_buf.push_back(tdms_pkg::CharDot);
      else append_separator();
    end else begin
      // second dot in a number, digit after it or not
      append_digits($urandom_range(1, 2));
      text_buf.push_back(tdms_pkg::CharDot);
      append_digits($urandom_range(1, 2));
      text_buf.push_back(tdms_pkg::CharDot);
      if ($urandom_range(0, 3) != 0) append_digits($urandom_range(1, 2));
      else append_separator();
    end
  endtask

  initial begin
    int sent;
    int target;
    char_bus.valid     <= 1'b0;
    char_bus.char_code <= '0;
    char_bus.last_char <= 1'b0;
    rst_ni             <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturation, text ending inside a number
    text_buf.delete();
    load_string("9999999999");
    send_text();

    // leading dot, dot before a non-digit, truncated fraction, digit after 2nd dot, trailing dot
    text_buf.delete();
    text_buf.push_back(8'hFF);
    load_string(".5..3.123456.2.");
    send_text();

    // no number at all
    text_buf.delete();
    text_buf.push_back(8'h00);
    send_text();

    sent = 0;
    while (sent < 800) begin
      text_buf.delete();
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      while (text_buf.size() < target) append_token();
      sent += text_buf.size();
      send_text();
    end
    char_bus.valid <= 1'b0;

    @(posedge clk_i);
    while (checker_pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (checker_fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls with occasional stall-free stretches
  initial begin
    int gap;
    result_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 7) == 0) taker_no_stalls = ~taker_no_stalls;
      gap = taker_no_stalls ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!result_bus.valid);
    end
  end

endmodule

`default_nettype wire

/* text_decimal_minimum_scanner.f */
hw/rtl/tdms_pkg.sv
hw/rtl/tdms_if.sv
hw/rtl/tdms_front.sv
hw/rtl/tdms_queue.sv
hw/rtl/tdms_back.sv
hw/rtl/text_decimal_minimum_scanner.sv
dv/tdms_min_checker.sv
dv/text_decimal_minimum_scanner_test.sv
